// ----- src/hhfe_pkg.sv -----
package hhfe_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 12;
  localparam int NLEN_W      = 5;

  // register map of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_LEN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_LF   = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    OUT_FOUND     = 2'd0,
    OUT_NOT_FOUND = 2'd1,
    OUT_NO_COLON  = 2'd2
  } outcome_t;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_COLON  = 7'b0000010,
    PH_LWS    = 7'b0000100,
    PH_LWS_CR = 7'b0001000,
    PH_LWS_NL = 7'b0010000,
    PH_VALUE  = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0]       value_byte;
    logic             value_valid;
    logic             finished;
    outcome_t         outcome;
    logic [LEN_W-1:0] value_length;
  } result_t;

  // width of the effective value length limit for a given maximum
  function automatic int limit_width(input int vmax);
    if (vmax >= 4095) begin
      return LEN_W;
    end
    return $clog2(vmax + 1);
  endfunction

endpackage

// ----- src/hhfe_cfg.sv -----
module hhfe_cfg #(
  parameter int NAME_BYTES_MAX = 16,
  parameter int VALUE_LEN_MAX  = 4095
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [hhfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data,
  output logic [NAME_BYTES_MAX*8-1:0]        name_bytes,
  output logic [hhfe_pkg::NLEN_W-1:0]        name_length,
  output logic [hhfe_pkg::limit_width(VALUE_LEN_MAX)-1:0] limit,
  output logic                               allow_bare_lf
);
  import hhfe_pkg::*;

  localparam int LIMIT_W = limit_width(VALUE_LEN_MAX);
  localparam logic [LIMIT_W-1:0] LIMIT_RST =
    (VALUE_LEN_MAX > 4095) ? LIMIT_W'(4095) : LIMIT_W'(VALUE_LEN_MAX);

  logic [LEN_W-1:0] max_len_wr;

  assign max_len_wr = cfg_data[LEN_W-1:0];

  // only the bytes that can ever be compared are stored
  always_ff @(posedge clk) begin
    if (rst) begin
      name_bytes <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NAME_BYTES_MAX; i++) begin
        if (cfg_index == ((i < 8) ? REG_NAME_LOW : REG_NAME_HIGH)) begin
          name_bytes[i*8 +: 8] <= cfg_data[(i % 8)*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length   <= NLEN_W'(1);
      limit         <= LIMIT_RST;
      allow_bare_lf <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NAME_LEN: name_length <= cfg_data[NLEN_W-1:0];
        REG_MAX_LEN: begin
          // clamp once at write time
          if (32'(max_len_wr) > VALUE_LEN_MAX) begin
            limit <= LIMIT_RST;
          end else begin
            limit <= LIMIT_W'(max_len_wr);
          end
        end
        REG_ALLOW_LF: allow_bare_lf <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/hhfe_scan.sv -----
module hhfe_scan #(
  parameter int NAME_BYTES_MAX = 16,
  parameter int VALUE_LEN_MAX  = 4095
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [7:0]                         text_byte,
  input  logic                               end_of_text,
  input  logic [NAME_BYTES_MAX*8-1:0]        name_bytes,
  input  logic [hhfe_pkg::NLEN_W-1:0]        name_length,
  input  logic [hhfe_pkg::limit_width(VALUE_LEN_MAX)-1:0] limit,
  input  logic                               allow_bare_lf,
  output hhfe_pkg::result_t                  res
);
  import hhfe_pkg::*;

  localparam int LIMIT_W = limit_width(VALUE_LEN_MAX);
  localparam int IDX_W   = (NAME_BYTES_MAX > 1) ? $clog2(NAME_BYTES_MAX) : 1;
  localparam logic [NLEN_W-1:0] NLEN_MAX = NLEN_W'(NAME_BYTES_MAX);

  phase_t              phase, phase_next;
  logic [NLEN_W-1:0]   match_cnt, match_cnt_next;
  logic                line_start, line_start_next;
  logic [LIMIT_W-1:0]  emitted, emitted_next;

  logic [NLEN_W-1:0]   nlen;
  logic [IDX_W-1:0]    name_idx;
  logic [7:0]          name_sel;
  logic                used;
  logic                emit;
  logic                fin;
  logic                is_wsp;
  outcome_t            outc;

  assign nlen     = (name_length > NLEN_MAX) ? NLEN_MAX : name_length;
  assign name_idx = match_cnt[IDX_W-1:0];
  assign name_sel = name_bytes[name_idx*8 +: 8];
  assign is_wsp   = (text_byte == CH_SPACE) || (text_byte == CH_TAB);

  always_comb begin
    phase_next      = phase;
    match_cnt_next  = match_cnt;
    line_start_next = line_start;
    emitted_next    = emitted;
    used            = 1'b0;
    emit            = 1'b0;
    fin             = 1'b0;
    outc            = OUT_FOUND;

    // name match at a line start; any other byte is consumed here
    if (phase_next == PH_SEARCH) begin
      if (line_start && match_cnt >= nlen) begin
        phase_next = PH_COLON;
      end else if (line_start && name_sel == text_byte) begin
        match_cnt_next = match_cnt + NLEN_W'(1);
        if (match_cnt_next >= nlen) begin
          phase_next = PH_COLON;
        end
        used = 1'b1;
      end else begin
        match_cnt_next  = '0;
        line_start_next = (text_byte == CH_LF);
        used            = 1'b1;
      end
    end

    if (phase_next == PH_COLON && !used) begin
      if (text_byte == CH_COLON) begin
        if (limit == '0) begin
          fin        = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_LWS;
        end
      end
      used = 1'b1;
    end

    // linear whitespace between the colon and the value
    if (!used) begin
      unique case (phase_next)
        PH_LWS: begin
          if (is_wsp) begin
            used = 1'b1;
          end else if (text_byte == CH_CR) begin
            phase_next = PH_LWS_CR;
            used       = 1'b1;
          end else if (text_byte == CH_LF) begin
            if (allow_bare_lf) begin
              phase_next = PH_LWS_NL;
            end else begin
              fin        = 1'b1;
              phase_next = PH_DONE;
            end
            used = 1'b1;
          end else begin
            phase_next = PH_VALUE;
          end
        end
        PH_LWS_CR: begin
          if (text_byte == CH_LF) begin
            phase_next = PH_LWS_NL;
          end else begin
            fin        = 1'b1;
            phase_next = PH_DONE;
          end
          used = 1'b1;
        end
        PH_LWS_NL: begin
          if (is_wsp) begin
            phase_next = PH_LWS;
          end else begin
            fin        = 1'b1;
            phase_next = PH_DONE;
          end
          used = 1'b1;
        end
        default: ;
      endcase
    end

    if (phase_next == PH_VALUE && !used) begin
      if (text_byte == CH_CR || text_byte == CH_LF) begin
        fin        = 1'b1;
        phase_next = PH_DONE;
      end else begin
        emit         = 1'b1;
        emitted_next = emitted + LIMIT_W'(1);
        if (emitted_next >= limit) begin
          fin        = 1'b1;
          phase_next = PH_DONE;
        end
      end
    end

    // early end of text closes with the outcome of the current phase
    if (end_of_text && !fin && phase_next != PH_DONE) begin
      fin = 1'b1;
      if (phase_next == PH_SEARCH) begin
        outc = OUT_NOT_FOUND;
      end else if (phase_next == PH_COLON) begin
        outc = OUT_NO_COLON;
      end else begin
        outc = OUT_FOUND;
      end
    end

    res.value_byte   = emit ? text_byte : 8'h00;
    res.value_valid  = emit;
    res.finished     = fin;
    res.outcome      = fin ? outc : OUT_FOUND;
    res.value_length = fin ? LEN_W'(emitted_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      match_cnt  <= '0;
      line_start <= 1'b1;
      emitted    <= '0;
    end else if (step) begin
      if (end_of_text) begin
        // restart for the next text
        phase      <= PH_SEARCH;
        match_cnt  <= '0;
        line_start <= 1'b1;
        emitted    <= '0;
      end else begin
        phase      <= phase_next;
        match_cnt  <= match_cnt_next;
        line_start <= line_start_next;
        emitted    <= emitted_next;
      end
    end
  end

endmodule

// ----- src/http_header_field_extract.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        text_byte, end_of_text
// out      output     out_valid / out_ready      value_byte, value_valid, finished,
//                                                outcome, value_length
// cfg      input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte per cycle sustained while no result is stalled; an item passes through the
// input register and then, if it yields a result, sits in the result register until
// taken. The scan state updates as the item leaves the input register.
// Synchronous active-high reset clears state and loads register defaults; cfg_ready
// is always high. A stalled result only blocks the input once the input register
// also holds an item.
module http_header_field_extract #(
  parameter int NAME_BYTES_MAX = 16,
  parameter int VALUE_LEN_MAX  = 4095
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        text_byte,
  input  logic                              end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        value_byte,
  output logic                              value_valid,
  output logic                              finished,
  output logic [1:0]                        outcome,
  output logic [hhfe_pkg::LEN_W-1:0]        value_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hhfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);
  import hhfe_pkg::*;

  localparam int LIMIT_W = limit_width(VALUE_LEN_MAX);

  logic [NAME_BYTES_MAX*8-1:0] name_bytes;
  logic [NLEN_W-1:0]           name_length;
  logic [LIMIT_W-1:0]          limit;
  logic                        allow_bare_lf;

  logic       buf_valid;
  logic [7:0] buf_byte;
  logic       buf_last;
  logic       advance;
  result_t    res;
  result_t    res_reg;

  assign cfg_ready = 1'b1;
  assign advance   = buf_valid && (!out_valid || out_ready);
  assign in_ready  = !buf_valid || advance;

  hhfe_cfg #(
    .NAME_BYTES_MAX (NAME_BYTES_MAX),
    .VALUE_LEN_MAX  (VALUE_LEN_MAX)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .name_bytes    (name_bytes),
    .name_length   (name_length),
    .limit         (limit),
    .allow_bare_lf (allow_bare_lf)
  );

  hhfe_scan #(
    .NAME_BYTES_MAX (NAME_BYTES_MAX),
    .VALUE_LEN_MAX  (VALUE_LEN_MAX)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .text_byte     (buf_byte),
    .end_of_text   (buf_last),
    .name_bytes    (name_bytes),
    .name_length   (name_length),
    .limit         (limit),
    .allow_bare_lf (allow_bare_lf),
    .res           (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_ready) begin
      buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_byte <= text_byte;
      buf_last <= end_of_text;
    end
  end

  // result register; drop items that yield nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (res.value_valid || res.finished)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (res.value_valid || res.finished)) begin
      res_reg <= res;
    end
  end

  assign value_byte   = res_reg.value_byte;
  assign value_valid  = res_reg.value_valid;
  assign finished     = res_reg.finished;
  assign outcome      = res_reg.outcome;
  assign value_length = res_reg.value_length;

endmodule
